[design/gsq_pkg.sv]
// Shared types and constants for the gate and slot sensor qualifier.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gsq_pkg;

    localparam int unsigned GATE_CH   = 4;
    localparam int unsigned SLOT_BITS = 4;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned DEB_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned S_DATA_W  = 48;
    localparam int unsigned M_DATA_W  = 32;

    localparam logic [DEB_W-1:0]     GATE_DEB_RST = 16'd500;
    localparam logic [DEB_W-1:0]     SLOT_DEB_RST = 16'd1000;
    localparam logic [TIME_W-1:0]    TIMEOUT_RST  = 32'd1800000;
    localparam logic [GATE_CH-1:0]   GATE_POL_RST = 4'd7;
    localparam logic [SLOT_BITS-1:0] SLOT_POL_RST = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GATE_DEBOUNCE = 3'd0,
        CFG_SLOT_DEBOUNCE = 3'd1,
        CFG_ACT_TIMEOUT   = 3'd2,
        CFG_GATE_POLARITY = 3'd3,
        CFG_SLOT_POLARITY = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic state;
        logic change;
    } t_lane_stat;

    // first member sits in the highest bits
    typedef struct packed {
        logic                 low_power;
        logic [1:0]           auto_closed;
        logic                 exit_raised;
        logic                 entry_raised;
        logic [6:0]           occupancy_percent;
        logic [2:0]           occupied_count;
        logic [SLOT_BITS-1:0] slot_changed;
        logic [SLOT_BITS-1:0] slot_occupied;
        logic [GATE_CH-1:0]   gate_rise;
        logic [GATE_CH-1:0]   gate_active;
    } t_result;

endpackage

`default_nettype wire

[design/gsq_lane.sv]
// One debounced sensor channel: qualified state and last accepted change time.
// Depends on gsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsq_lane (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic                       i_sample,
    input  wire logic [gsq_pkg::TIME_W-1:0] i_now,
    input  wire logic [gsq_pkg::DEB_W-1:0]  i_debounce,
    input  wire logic                       i_detect,
    output gsq_pkg::t_lane_stat             o_stat
);

    logic                       r_state;
    logic [gsq_pkg::TIME_W-1:0] r_last;
    logic [gsq_pkg::TIME_W-1:0] w_elapsed;
    logic                       w_flip;
    logic                       n_state;

    assign w_elapsed = i_now - r_last;
    assign w_flip    = i_sample && (i_detect != r_state) &&
                       (w_elapsed > {{(gsq_pkg::TIME_W-gsq_pkg::DEB_W){1'b0}}, i_debounce});
    assign n_state   = r_state ^ w_flip;

    assign o_stat.state  = n_state;
    assign o_stat.change = w_flip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= 1'b0;
            r_last  <= '0;
        end else if (i_accept && w_flip) begin
            r_state <= n_state;
            r_last  <= i_now;
        end
    end

endmodule

`default_nettype wire

[design/gsq_merge.sv]
// Merges lane findings: barriers, activity time, low power, count and percent.
// Depends on gsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsq_merge #(
    parameter int unsigned NUM_SLOTS = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic                       i_sample,
    input  wire logic [gsq_pkg::TIME_W-1:0] i_now,
    input  wire logic                       i_barrier_sel,
    input  wire logic                       i_barrier_open,
    input  wire logic [gsq_pkg::TIME_W-1:0] i_timeout,
    input  wire gsq_pkg::t_lane_stat        i_gate_stat [gsq_pkg::GATE_CH],
    input  wire gsq_pkg::t_lane_stat        i_slot_stat [gsq_pkg::SLOT_BITS],
    output gsq_pkg::t_result                o_res
);

    localparam logic [6:0] PCT_1 = 7'(100 / NUM_SLOTS);
    localparam logic [6:0] PCT_2 = 7'(200 / NUM_SLOTS);
    localparam logic [6:0] PCT_3 = 7'(300 / NUM_SLOTS);
    localparam logic [6:0] PCT_4 = 7'(400 / NUM_SLOTS);

    logic                         r_entry;
    logic                         r_exit;
    logic                         r_low_power;
    logic [gsq_pkg::TIME_W-1:0]   r_last_act;
    logic                         n_entry;
    logic                         n_exit;
    logic                         n_low_power;
    logic [gsq_pkg::TIME_W-1:0]   n_last_act;

    logic [gsq_pkg::GATE_CH-1:0]   w_gate_state;
    logic [gsq_pkg::GATE_CH-1:0]   w_rise;
    logic [gsq_pkg::SLOT_BITS-1:0] w_slot_state;
    logic [gsq_pkg::SLOT_BITS-1:0] w_slot_chg;
    logic [gsq_pkg::TIME_W-1:0]    w_idle;
    logic                          w_timed_out;
    logic [2:0]                    w_count;
    logic [6:0]                    w_pct;
    logic [1:0]                    w_auto;

    always_comb begin
        for (int i = 0; i < gsq_pkg::GATE_CH; i++) begin
            w_gate_state[i] = i_gate_stat[i].state;
            w_rise[i]       = i_gate_stat[i].change & i_gate_stat[i].state;
        end
        w_count = '0;
        for (int i = 0; i < gsq_pkg::SLOT_BITS; i++) begin
            w_slot_state[i] = i_slot_stat[i].state;
            w_slot_chg[i]   = i_slot_stat[i].change;
            w_count         = w_count + {2'b00, i_slot_stat[i].state};
        end
    end

    assign w_idle      = i_now - r_last_act;
    assign w_timed_out = w_idle > i_timeout;
    assign w_auto      = {w_rise[3], w_rise[1]};

    always_comb begin
        unique case (w_count)
            3'd0:    w_pct = '0;
            3'd1:    w_pct = PCT_1;
            3'd2:    w_pct = PCT_2;
            3'd3:    w_pct = PCT_3;
            3'd4:    w_pct = PCT_4;
            default: w_pct = '0;
        endcase
    end

    always_comb begin
        n_entry     = r_entry;
        n_exit      = r_exit;
        n_low_power = r_low_power;
        n_last_act  = r_last_act;
        if (!i_sample) begin
            if (i_barrier_sel) begin
                n_exit = i_barrier_open;
            end else begin
                n_entry = i_barrier_open;
            end
            n_last_act = i_now;
        end else begin
            if (|w_rise) begin
                n_low_power = 1'b0;
            end else if (w_timed_out) begin
                n_low_power = 1'b1;
            end
            if (w_auto[0]) begin
                n_entry = 1'b0;
            end
            if (w_auto[1]) begin
                n_exit = 1'b0;
            end
            if ((|w_rise) || (|w_slot_chg)) begin
                n_last_act = i_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry     <= 1'b0;
            r_exit      <= 1'b0;
            r_low_power <= 1'b0;
            r_last_act  <= '0;
        end else if (i_accept) begin
            r_entry     <= n_entry;
            r_exit      <= n_exit;
            r_low_power <= n_low_power;
            r_last_act  <= n_last_act;
        end
    end

    assign o_res.gate_active       = w_gate_state;
    assign o_res.gate_rise         = w_rise;
    assign o_res.slot_occupied     = w_slot_state;
    assign o_res.slot_changed      = w_slot_chg;
    assign o_res.occupied_count    = w_count;
    assign o_res.occupancy_percent = w_pct;
    assign o_res.entry_raised      = n_entry;
    assign o_res.exit_raised       = n_exit;
    assign o_res.auto_closed       = w_auto;
    assign o_res.low_power         = n_low_power;

    a_entry_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.auto_closed[0] |-> !o_res.entry_raised)
        else $error("entry auto-close left barrier open");
    a_exit_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.auto_closed[1] |-> !o_res.exit_raised)
        else $error("exit auto-close left barrier open");
    a_rise_wakes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (o_res.gate_rise != '0)) |=> !r_low_power)
        else $error("gate rise did not clear low power");

endmodule

`default_nettype wire

[design/gate_and_slot_sensor_qualifier_core.sv]
// Top level of the gate and slot sensor qualifier: config registers, lanes,
// merge stage and registered output with skid. Depends on gsq_pkg, gsq_lane, gsq_merge.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------
//  s_axis    | i_s_axis_tvalid/o_..rdy | tdata 48b sample/command, tuser cmd
//  m_axis    | o_m_axis_tvalid/i_..rdy | tdata 32b qualified result
//  cfg       | i_cfg_valid/o_cfg_ready | i_cfg_index 3b, i_cfg_data 32b
//
// One beat per clock while o_s_axis_tready is high; each result is registered in the
// main or skid entry. All lanes and the merge stage evaluate in the accepting cycle.
// A two-deep output register (main + skid) decouples i_m_axis_tready;
// o_s_axis_tready drops only while the skid entry is full.
// Synchronous active-low reset restores register defaults and clears all but output data.
`timescale 1ns / 1ps
`default_nettype none

module gate_and_slot_sensor_qualifier_core #(
    parameter int unsigned NUM_SLOTS = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [31:0] now_ms, [35:32] gate_levels, [39:36] slot_levels,
    // [40] barrier_sel, [41] barrier_open, [47:42] zero
    input  wire logic [gsq_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    // [0] cmd
    input  wire logic                          i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [3:0] gate_active, [7:4] gate_rise, [11:8] slot_occupied,
    // [15:12] slot_changed, [18:16] occupied_count, [25:19] occupancy_percent,
    // [26] entry_raised, [27] exit_raised, [29:28] auto_closed, [30] low_power, [31] zero
    output logic [gsq_pkg::M_DATA_W-1:0]       o_m_axis_tdata,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [gsq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [gsq_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int unsigned SLOT_CH = (NUM_SLOTS < 4) ? NUM_SLOTS : 4;

    logic [gsq_pkg::DEB_W-1:0]     r_gate_deb;
    logic [gsq_pkg::DEB_W-1:0]     r_slot_deb;
    logic [gsq_pkg::TIME_W-1:0]    r_timeout;
    logic [gsq_pkg::GATE_CH-1:0]   r_gate_pol;
    logic [gsq_pkg::SLOT_BITS-1:0] r_slot_pol;

    logic                          w_accept;
    logic                          w_sample;
    logic [gsq_pkg::TIME_W-1:0]    w_now;
    logic [gsq_pkg::GATE_CH-1:0]   w_gate_det;
    logic [gsq_pkg::SLOT_BITS-1:0] w_slot_det;
    gsq_pkg::t_lane_stat           w_gate_stat [gsq_pkg::GATE_CH];
    gsq_pkg::t_lane_stat           w_slot_stat [gsq_pkg::SLOT_BITS];
    gsq_pkg::t_result              w_res;

    logic                          r_out_valid;
    logic                          r_skid_valid;
    gsq_pkg::t_result              r_out;
    gsq_pkg::t_result              r_skid;
    logic                          w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_deb <= gsq_pkg::GATE_DEB_RST;
            r_slot_deb <= gsq_pkg::SLOT_DEB_RST;
            r_timeout  <= gsq_pkg::TIMEOUT_RST;
            r_gate_pol <= gsq_pkg::GATE_POL_RST;
            r_slot_pol <= gsq_pkg::SLOT_POL_RST;
        end else if (i_cfg_valid) begin
            case (gsq_pkg::t_cfg_idx'(i_cfg_index))
                gsq_pkg::CFG_GATE_DEBOUNCE: r_gate_deb <= i_cfg_data[gsq_pkg::DEB_W-1:0];
                gsq_pkg::CFG_SLOT_DEBOUNCE: r_slot_deb <= i_cfg_data[gsq_pkg::DEB_W-1:0];
                gsq_pkg::CFG_ACT_TIMEOUT:   r_timeout  <= i_cfg_data;
                gsq_pkg::CFG_GATE_POLARITY: r_gate_pol <= i_cfg_data[gsq_pkg::GATE_CH-1:0];
                gsq_pkg::CFG_SLOT_POLARITY: r_slot_pol <= i_cfg_data[gsq_pkg::SLOT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = !r_skid_valid;
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_sample   = !i_s_axis_tuser;
    assign w_now      = i_s_axis_tdata[31:0];
    assign w_gate_det = ~(i_s_axis_tdata[35:32] ^ r_gate_pol);
    assign w_slot_det = ~(i_s_axis_tdata[39:36] ^ r_slot_pol);

    for (genvar g = 0; g < gsq_pkg::GATE_CH; g++) begin : g_gate
        gsq_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_accept   (w_accept),
            .i_sample   (w_sample),
            .i_now      (w_now),
            .i_debounce (r_gate_deb),
            .i_detect   (w_gate_det[g]),
            .o_stat     (w_gate_stat[g])
        );
    end

    for (genvar s = 0; s < gsq_pkg::SLOT_BITS; s++) begin : g_slot
        if (s < SLOT_CH) begin : g_on
            gsq_lane u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_accept   (w_accept),
                .i_sample   (w_sample),
                .i_now      (w_now),
                .i_debounce (r_slot_deb),
                .i_detect   (w_slot_det[s]),
                .o_stat     (w_slot_stat[s])
            );
        end else begin : g_off
            assign w_slot_stat[s] = '0;
        end
    end

    gsq_merge #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_sample       (w_sample),
        .i_now          (w_now),
        .i_barrier_sel  (i_s_axis_tdata[40]),
        .i_barrier_open (i_s_axis_tdata[41]),
        .i_timeout      (r_timeout),
        .i_gate_stat    (w_gate_stat),
        .i_slot_stat    (w_slot_stat),
        .o_res          (w_res)
    );

    assign w_pop = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (!w_accept) begin
                r_out_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && r_skid_valid) begin
            r_out <= r_skid;
        end else if (w_accept && (w_pop || !r_out_valid)) begin
            r_out <= w_res;
        end
        if (w_accept && r_out_valid && !w_pop) begin
            r_skid <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out};

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without main entry");
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($countones(r_out.slot_occupied) == 32'(r_out.occupied_count)))
        else $error("occupied count disagrees with slot map");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_m_axis_tready) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid entry lost under stall");

endmodule

`default_nettype wire

[test/gate_and_slot_sensor_qualifier_core_tb.sv]
// Self-checking testbench for gate_and_slot_sensor_qualifier_core: directed and random
// sensor samples and barrier commands under random stalls, checked against an inline predictor.
// Depends on gsq_pkg and the core RTL.
`timescale 1ns / 1ps

module gate_and_slot_sensor_qualifier_core_tb;

    localparam int unsigned SLOTS     = 4;
    localparam int unsigned SLOT_CH   = (SLOTS < 4) ? SLOTS : 4;
    localparam logic [3:0]  SLOT_MASK = 4'((1 << SLOT_CH) - 1);
    localparam int          ENTRY_GATE = 1;
    localparam int          EXIT_GATE  = 3;

    localparam logic CMD_SAMPLE  = 1'b0;
    localparam logic CMD_BARRIER = 1'b1;
    localparam logic BAR_ENTRY   = 1'b0;
    localparam logic BAR_EXIT    = 1'b1;
    localparam logic BAR_OPEN    = 1'b1;
    localparam logic BAR_CLOSE   = 1'b0;

    typedef struct {
        logic        cmd;
        logic [31:0] now;
        logic [3:0]  glev;
        logic [3:0]  slev;
        logic        sel;
        logic        opn;
    } t_sample;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [gsq_pkg::S_DATA_W-1:0]   i_s_axis_tdata = '0;
    logic                           i_s_axis_tuser = 1'b0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [gsq_pkg::M_DATA_W-1:0]   o_m_axis_tdata;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [gsq_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [gsq_pkg::CFG_DAT_W-1:0]  i_cfg_data = '0;

    gate_and_slot_sensor_qualifier_core #(
        .NUM_SLOTS(SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the block's registers and state
    logic [15:0] gate_deb, slot_deb;
    logic [31:0] act_tmo;
    logic [3:0]  gate_pol, slot_pol;
    logic [3:0]  gate_st, slot_st;
    logic [31:0] gate_last [4];
    logic [31:0] slot_last [4];
    logic        entry_f, exit_f, low_pwr;
    logic [31:0] last_act;

    t_sample          pending [$];
    gsq_pkg::t_result due_results [$];
    int               mismatches = 0;
    logic             calm = 1'b0;
    t_sample          drv_item;
    gsq_pkg::t_result want;
    string            diffs;

    // stimulus planning
    logic [15:0] plan_gdeb, plan_sdeb;
    logic [31:0] plan_tmo, plan_now;
    logic [3:0]  plan_glev, plan_slev;

    function automatic gsq_pkg::t_result qualify(input logic cmd, input logic [31:0] now,
                                                 input logic [3:0] glev,
                                                 input logic [3:0] slev,
                                                 input logic sel, input logic opn);
        gsq_pkg::t_result r;
        logic [3:0]       gdet, sdet, rise, chg;
        logic [1:0]       autoc;
        int               cnt;
        rise  = '0;
        chg   = '0;
        autoc = '0;
        if (cmd == CMD_BARRIER) begin
            if (sel == BAR_EXIT) exit_f = opn;
            else entry_f = opn;
            last_act = now;
        end else begin
            gdet = ~(glev ^ gate_pol);
            sdet = ~(slev ^ slot_pol) & SLOT_MASK;
            if (!low_pwr && (now - last_act) > act_tmo) low_pwr = 1'b1;
            for (int i = 0; i < 4; i++) begin
                if ((gdet[i] != gate_st[i]) && (now - gate_last[i]) > {16'h0, gate_deb}) begin
                    gate_st[i]   = ~gate_st[i];
                    gate_last[i] = now;
                    if (gate_st[i]) begin
                        rise[i]  = 1'b1;
                        last_act = now;
                        if (i == ENTRY_GATE) begin
                            entry_f  = 1'b0;
                            autoc[0] = 1'b1;
                        end
                        if (i == EXIT_GATE) begin
                            exit_f   = 1'b0;
                            autoc[1] = 1'b1;
                        end
                    end
                end
            end
            if (rise != 0) low_pwr = 1'b0;
            for (int i = 0; i < SLOT_CH; i++) begin
                if ((sdet[i] != slot_st[i]) && (now - slot_last[i]) > {16'h0, slot_deb}) begin
                    slot_st[i]   = ~slot_st[i];
                    slot_last[i] = now;
                    chg[i]       = 1'b1;
                    last_act     = now;
                end
            end
        end
        cnt = $countones(slot_st & SLOT_MASK);
        r.gate_active       = gate_st;
        r.gate_rise         = rise;
        r.slot_occupied     = slot_st & SLOT_MASK;
        r.slot_changed      = chg;
        r.occupied_count    = 3'(cnt);
        r.occupancy_percent = 7'((cnt * 100) / SLOTS);
        r.entry_raised      = entry_f;
        r.exit_raised       = exit_f;
        r.auto_closed       = autoc;
        r.low_power         = low_pwr;
        return r;
    endfunction

    function automatic string field_diffs(input gsq_pkg::t_result w,
                                          input logic [gsq_pkg::M_DATA_W-1:0] raw);
        gsq_pkg::t_result g;
        string            s;
        g = gsq_pkg::t_result'(raw[$bits(gsq_pkg::t_result)-1:0]);
        s = "";
        if (g.gate_active !== w.gate_active) s = {s, " gate_active"};
        if (g.gate_rise !== w.gate_rise) s = {s, " gate_rise"};
        if (g.slot_occupied !== w.slot_occupied) s = {s, " slot_occupied"};
        if (g.slot_changed !== w.slot_changed) s = {s, " slot_changed"};
        if (g.occupied_count !== w.occupied_count) s = {s, " occupied_count"};
        if (g.occupancy_percent !== w.occupancy_percent) s = {s, " occupancy_percent"};
        if (g.entry_raised !== w.entry_raised) s = {s, " entry_raised"};
        if (g.exit_raised !== w.exit_raised) s = {s, " exit_raised"};
        if (g.auto_closed !== w.auto_closed) s = {s, " auto_closed"};
        if (g.low_power !== w.low_power) s = {s, " low_power"};
        if (raw[gsq_pkg::M_DATA_W-1:$bits(gsq_pkg::t_result)] !== '0) s = {s, " spare"};
        return s;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // driver: one beat per free slot, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 26)) begin
                drv_item = pending.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {6'b0, drv_item.opn, drv_item.sel, drv_item.slev,
                                    drv_item.glev, drv_item.now};
                i_s_axis_tuser  <= drv_item.cmd;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: register shadow, result check, prediction of accepted beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gate_deb = gsq_pkg::GATE_DEB_RST;
            slot_deb = gsq_pkg::SLOT_DEB_RST;
            act_tmo  = gsq_pkg::TIMEOUT_RST;
            gate_pol = gsq_pkg::GATE_POL_RST;
            slot_pol = gsq_pkg::SLOT_POL_RST;
            gate_st  = '0;
            slot_st  = '0;
            for (int i = 0; i < 4; i++) begin
                gate_last[i] = '0;
                slot_last[i] = '0;
            end
            entry_f  = 1'b0;
            exit_f   = 1'b0;
            low_pwr  = 1'b0;
            last_act = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    gsq_pkg::CFG_GATE_DEBOUNCE: gate_deb = i_cfg_data[15:0];
                    gsq_pkg::CFG_SLOT_DEBOUNCE: slot_deb = i_cfg_data[15:0];
                    gsq_pkg::CFG_ACT_TIMEOUT:   act_tmo  = i_cfg_data;
                    gsq_pkg::CFG_GATE_POLARITY: gate_pol = i_cfg_data[3:0];
                    gsq_pkg::CFG_SLOT_POLARITY: slot_pol = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (due_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat %08h", o_m_axis_tdata));
                end else begin
                    want  = due_results.pop_front();
                    diffs = field_diffs(want, o_m_axis_tdata);
                    if (diffs != "")
                        note_mismatch($sformatf("fields%s: expected %08h got %08h",
                                                diffs, {1'b0, want}, o_m_axis_tdata));
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                due_results.push_back(qualify(i_s_axis_tuser, i_s_axis_tdata[31:0],
                                              i_s_axis_tdata[35:32], i_s_axis_tdata[39:36],
                                              i_s_axis_tdata[40], i_s_axis_tdata[41]));
        end
        i_m_axis_tready <= calm || ($urandom_range(0, 99) >= 26);
    end

    task automatic cfg_write(input logic [gsq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // upper bits of the narrow registers carry junk that must be dropped
    task automatic set_config(input logic [15:0] gd, input logic [15:0] sd,
                              input logic [31:0] tmo, input logic [3:0] gp,
                              input logic [3:0] sp);
        cfg_write(gsq_pkg::CFG_GATE_DEBOUNCE, {16'($urandom()), gd});
        cfg_write(gsq_pkg::CFG_SLOT_DEBOUNCE, {16'($urandom()), sd});
        cfg_write(gsq_pkg::CFG_ACT_TIMEOUT, tmo);
        cfg_write(gsq_pkg::CFG_GATE_POLARITY, {28'($urandom()), gp});
        cfg_write(gsq_pkg::CFG_SLOT_POLARITY, {28'($urandom()), sp});
        plan_gdeb = gd;
        plan_sdeb = sd;
        plan_tmo  = tmo;
    endtask

    task automatic add_sample(input logic [31:0] now, input logic [3:0] glev,
                              input logic [3:0] slev);
        t_sample s;
        s.cmd  = CMD_SAMPLE;
        s.now  = now;
        s.glev = glev;
        s.slev = slev;
        s.sel  = 1'($urandom());
        s.opn  = 1'($urandom());
        pending.push_back(s);
    endtask

    task automatic add_command(input logic [31:0] now, input logic sel, input logic opn);
        t_sample s;
        s.cmd  = CMD_BARRIER;
        s.now  = now;
        s.glev = 4'($urandom());
        s.slev = 4'($urandom());
        s.sel  = sel;
        s.opn  = opn;
        pending.push_back(s);
    endtask

    task automatic run_random(input int count);
        t_sample     s;
        int          r;
        logic [31:0] step, span;
        for (int k = 0; k < count; k++) begin
            span = (plan_gdeb > plan_sdeb) ? {16'h0, plan_gdeb} : {16'h0, plan_sdeb};
            r = $urandom_range(0, 99);
            if (r < 10) step = '0;
            else if (r < 22) step = plan_gdeb + $urandom_range(0, 1);
            else if (r < 32) step = plan_sdeb + $urandom_range(0, 1);
            else if (r < 38) step = plan_tmo + $urandom_range(0, 1);
            else if (r < 44) step = $urandom();
            else step = $urandom_range(0, span + span / 2 + 2);
            plan_now = plan_now + step;
            r = $urandom_range(0, 99);
            if (r >= 75) begin
                plan_glev = 4'($urandom());
                plan_slev = 4'($urandom());
            end else if (r >= 45) begin
                plan_glev = plan_glev ^ (4'b1 << $urandom_range(0, 3));
                plan_slev = plan_slev ^ (4'b1 << $urandom_range(0, 3));
            end
            s.cmd  = ($urandom_range(0, 99) < 20) ? CMD_BARRIER : CMD_SAMPLE;
            s.now  = plan_now;
            s.glev = plan_glev;
            s.slev = plan_slev;
            s.sel  = 1'($urandom());
            s.opn  = 1'($urandom());
            pending.push_back(s);
        end
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending.size() != 0 || i_s_axis_tvalid || due_results.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    initial begin
        plan_gdeb = gsq_pkg::GATE_DEB_RST;
        plan_sdeb = gsq_pkg::SLOT_DEB_RST;
        plan_tmo  = gsq_pkg::TIMEOUT_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset register values
        add_sample(32'd0, 4'h0, 4'h0);
        add_sample(32'd500, 4'h0, 4'h0);             // elapsed equals debounce
        add_sample(32'd501, 4'h0, 4'h0);             // exit gate rises, auto-close
        add_command(32'd600, BAR_ENTRY, BAR_OPEN);
        add_command(32'd700, BAR_EXIT, BAR_OPEN);
        add_sample(32'd1200, 4'h7, 4'hF);            // entry gate rises, auto-close, all slots full
        add_sample(32'd1201, 4'h8, 4'h0);
        add_sample(32'd1701, 4'h8, 4'h0);
        add_sample(32'd2201, 4'h8, 4'h0);
        add_sample(32'd1802202, 4'h8, 4'h0);         // idle past timeout
        add_command(32'd1802300, BAR_EXIT, BAR_OPEN);
        add_sample(32'd1802400, 4'h8, 4'h0);
        add_sample(32'd1802500, 4'h7, 4'h0);         // rise leaves low power
        add_sample(32'hFFFF_FF00, 4'hF, 4'hA);
        add_sample(32'h0000_0100, 4'h0, 4'h5);       // counter wrap
        add_sample(32'hFFFF_FFFF, 4'hF, 4'hF);
        add_sample(32'hFFFF_FFFF, 4'h0, 4'h0);
        add_command(32'hFFFF_FFFF, BAR_ENTRY, BAR_CLOSE);
        add_command(32'h0000_0000, BAR_EXIT, BAR_CLOSE);
        drain();
        plan_now  = '0;
        plan_glev = '0;
        plan_slev = '0;

        set_config(16'h0, 16'h0, 32'h0, 4'h0, 4'h0);
        run_random(155);
        drain();

        set_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 4'hF);
        run_random(155);
        drain();

        set_config(16'($urandom_range(1, 300)), 16'($urandom_range(1, 600)),
                   32'($urandom_range(0, 4000)), 4'($urandom()), 4'($urandom()));
        calm <= 1'b1;
        run_random(155);
        drain();
        calm <= 1'b0;

        // writes to unused indexes must be dropped
        for (int j = int'(gsq_pkg::CFG_SLOT_POLARITY) + 1; j < (1 << gsq_pkg::CFG_IDX_W); j++)
            cfg_write(gsq_pkg::CFG_IDX_W'(j), $urandom());
        set_config(16'($urandom()), 16'($urandom()), $urandom(),
                   4'($urandom()), 4'($urandom()));
        run_random(155);
        drain();

        set_config(gsq_pkg::GATE_DEB_RST, gsq_pkg::SLOT_DEB_RST, gsq_pkg::TIMEOUT_RST,
                   4'($urandom()), 4'($urandom()));
        run_random(155);
        drain();

        set_config(16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
                   32'($urandom_range(0, 200)), 4'($urandom()), 4'($urandom()));
        run_random(155);
        drain();

        if (mismatches == 0 && due_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
design/gsq_pkg.sv
design/gsq_lane.sv
design/gsq_merge.sv
design/gate_and_slot_sensor_qualifier_core.sv
test/gate_and_slot_sensor_qualifier_core_tb.sv
